/* src/rot_pkg.sv */
`timescale 1ns / 1ps

package rot_pkg;

   localparam int COORD_BITS = 21;
   localparam int FRAC_BITS  = 10;

   localparam int FIELD_W = 63;
   localparam int OPAC_W  = 17;
   localparam int VW      = 3 * COORD_BITS;
   localparam int DW      = COORD_BITS + 1;
   localparam int CW      = 2 * DW + 1;
   localparam int SPLIT   = DW + 1;
   localparam int SW      = CW + DW + 2;
   localparam int MW      = (DW + 2 > 21) ? DW + 2 : 21;
   localparam int PW      = 2 * MW;
   localparam int AW      = SW + 21;

   localparam longint EPS_INV = 64'd1000000;
   localparam longint EPS_MIN = ((longint'(1) << (3 * FRAC_BITS)) + EPS_INV - 1) / EPS_INV;

   localparam int STEP_W    = 6;
   localparam int LAST_STEP = 38;

   localparam logic [OPAC_W-1:0] ONE_Q16 = 17'h10000;

   typedef enum logic [2:0] {A_DIR, A_E1, A_E2, A_S, A_ST} a_src_type;
   typedef enum logic [2:0] {B_E1, B_E2, B_H_LO, B_H_HI, B_Q_LO, B_Q_HI, B_K} b_src_type;
   typedef enum logic [2:0] {W_NONE, W_H, W_Q, W_ST, W_DET, W_SU, W_SV} w_dst_type;
   typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_CMP1, S_CMP2} seq_state_type;

   typedef struct packed {
      a_src_type a_src;
      logic [1:0] a_comp;
      b_src_type b_src;
      logic [1:0] b_comp;
      logic sub;
      logic [1:0] shift;
      logic clr;
      w_dst_type dst;
      logic [1:0] dst_comp;
   } step_ctrl_type;

   typedef struct packed {
      logic cmp1;
      logic cmp2;
   } seq_phase_type;

   function automatic logic [1:0] next_comp(input logic [1:0] i);
      case (i)
         2'd0:    return 2'd1;
         2'd1:    return 2'd2;
         default: return 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] prev_comp(input logic [1:0] i);
      case (i)
         2'd0:    return 2'd2;
         2'd1:    return 2'd0;
         default: return 2'd1;
      endcase
   endfunction

   // step schedule: h, q, e2.q, e1.h, s.h, dir.q, then e2.q times 1e6
   function automatic step_ctrl_type step_ctrl(input logic [STEP_W-1:0] step);
      step_ctrl_type c;
      logic [STEP_W-1:0] j;
      logic [1:0] i;
      c.a_src    = A_DIR;
      c.a_comp   = 2'd0;
      c.b_src    = B_E1;
      c.b_comp   = 2'd0;
      c.sub      = 1'b0;
      c.shift    = 2'd0;
      c.clr      = 1'b0;
      c.dst      = W_NONE;
      c.dst_comp = 2'd0;
      if (step < STEP_W'(12)) begin
         j = (step < STEP_W'(6)) ? step : step - STEP_W'(6);
         i = j[2:1];
         c.a_src = (step < STEP_W'(6)) ? A_DIR : A_S;
         c.b_src = (step < STEP_W'(6)) ? B_E2 : B_E1;
         if (!j[0]) begin
            c.a_comp = next_comp(i);
            c.b_comp = prev_comp(i);
            c.clr    = 1'b1;
         end else begin
            c.a_comp   = prev_comp(i);
            c.b_comp   = next_comp(i);
            c.sub      = 1'b1;
            c.dst      = (step < STEP_W'(6)) ? W_H : W_Q;
            c.dst_comp = i;
         end
      end else if (step < STEP_W'(36)) begin
         if (step < STEP_W'(18)) begin
            j = step - STEP_W'(12);
            c.a_src = A_E2;
            c.dst   = W_ST;
         end else if (step < STEP_W'(24)) begin
            j = step - STEP_W'(18);
            c.a_src = A_E1;
            c.dst   = W_DET;
         end else if (step < STEP_W'(30)) begin
            j = step - STEP_W'(24);
            c.a_src = A_S;
            c.dst   = W_SU;
         end else begin
            j = step - STEP_W'(30);
            c.a_src = A_DIR;
            c.dst   = W_SV;
         end
         i = j[2:1];
         c.a_comp = i;
         c.b_comp = i;
         if (c.dst == W_ST || c.dst == W_SV) begin
            c.b_src = j[0] ? B_Q_HI : B_Q_LO;
         end else begin
            c.b_src = j[0] ? B_H_HI : B_H_LO;
         end
         c.shift = {1'b0, j[0]};
         c.clr   = (j == STEP_W'(0));
         if (j != STEP_W'(5)) begin
            c.dst = W_NONE;
         end
      end else begin
         j = step - STEP_W'(36);
         c.a_src  = A_ST;
         c.a_comp = j[1:0];
         c.b_src  = B_K;
         c.shift  = j[1:0];
         c.clr    = (j == STEP_W'(0));
      end
      return c;
   endfunction

endpackage

/* src/rot_mul_acc.sv */
`timescale 1ns / 1ps

module rot_mul_acc (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         ctrl_valid,
   input  rot_pkg::step_ctrl_type       ctrl,
   input  logic signed [rot_pkg::MW-1:0] a_op,
   input  logic signed [rot_pkg::MW-1:0] b_op,
   output logic signed [rot_pkg::AW-1:0] acc,
   output logic                         wr_en,
   output rot_pkg::w_dst_type           wr_dst,
   output logic [1:0]                   wr_comp,
   output logic signed [rot_pkg::AW-1:0] wr_value
);
   import rot_pkg::*;

   logic signed [PW-1:0] prod_ff;
   step_ctrl_type        ctrl_ff;
   logic                 pvalid_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [AW-1:0] acc_in;
   logic signed [AW-1:0] base;
   logic signed [AW-1:0] term;
   logic signed [AW-1:0] shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= ctrl_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_op * b_op;
      ctrl_ff <= ctrl;
      acc_ff  <= acc_in;
   end

   always_comb begin
      base = ctrl_ff.clr ? '0 : acc_ff;
      term = AW'(prod_ff);
      if (ctrl_ff.sub) begin
         term = -term;
      end
      case (ctrl_ff.shift)
         2'd0:    shifted = term;
         2'd1:    shifted = term <<< SPLIT;
         default: shifted = term <<< (2 * SPLIT);
      endcase
      acc_in = pvalid_ff ? base + shifted : acc_ff;
   end

   assign acc      = acc_ff;
   assign wr_en    = pvalid_ff && (ctrl_ff.dst != W_NONE);
   assign wr_dst   = ctrl_ff.dst;
   assign wr_comp  = ctrl_ff.dst_comp;
   assign wr_value = acc_in;

endmodule

/* src/rot_seq.sv */
`timescale 1ns / 1ps

module rot_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   hold,
   output logic                   ready,
   output logic                   ctrl_valid,
   output rot_pkg::step_ctrl_type ctrl,
   output rot_pkg::seq_phase_type phase
);
   import rot_pkg::*;

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      ready      = 1'b0;
      ctrl_valid = 1'b0;
      phase.cmp1 = 1'b0;
      phase.cmp2 = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            ready = 1'b1;
            if (start) begin
               state_in = S_RUN;
               step_in  = '0;
            end
         end
         S_RUN: begin
            ctrl_valid = 1'b1;
            step_in    = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(LAST_STEP)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_CMP1;
         S_CMP1: begin
            phase.cmp1 = 1'b1;
            state_in   = S_CMP2;
         end
         S_CMP2: begin
            phase.cmp2 = 1'b1;
            if (!hold) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign ctrl = step_ctrl(step_ff);

endmodule

/* src/ray_occlusion_transmission_unit.sv */
`timescale 1ns / 1ps

// channel | handshake            | payload
// req     | req_valid, req_ready | ray_start, corner_a/b/c, opacity, first/last_of_ray
// rsp     | rsp_valid, rsp_ready | transmission, any_hit
// csr     | csr_wr_en            | csr_wr_data (sun direction)
//
// between one accept and the next, an item runs every product of steps 0 to LAST_STEP
// through the single shared multiplier, then the accumulate drain state, the compare
// states cmp1 and cmp2, and the idle state with ready high
// the multiplier sequence sets the pace; no item is taken meanwhile
// synchronous active-high reset; transmission 1.0, no hit, sun direction zero
// a pending result only stalls the block at the end of a last item

module ray_occlusion_transmission_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rot_pkg::FIELD_W-1:0]   req_ray_start,
   input  logic [rot_pkg::FIELD_W-1:0]   req_corner_a,
   input  logic [rot_pkg::FIELD_W-1:0]   req_corner_b,
   input  logic [rot_pkg::FIELD_W-1:0]   req_corner_c,
   input  logic [rot_pkg::OPAC_W-1:0]    req_opacity,
   input  logic                          req_first_of_ray,
   input  logic                          req_last_of_ray,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rot_pkg::OPAC_W-1:0]    rsp_transmission,
   output logic                          rsp_any_hit,
   input  logic                          csr_wr_en,
   input  logic [rot_pkg::FIELD_W-1:0]   csr_wr_data
);
   import rot_pkg::*;

   logic                     accept;
   logic                     hold;
   logic                     advance;
   logic                     ctrl_valid;
   step_ctrl_type            ctrl;
   seq_phase_type            phase;
   logic signed [MW-1:0]     a_op, b_op;
   logic signed [AW-1:0]     acc;
   logic                     wr_en;
   w_dst_type                wr_dst;
   logic [1:0]               wr_comp;
   logic signed [AW-1:0]     wr_value;

   logic [FIELD_W-1:0]       sun_ff;
   logic signed [COORD_BITS-1:0] dir_c [3];
   logic signed [COORD_BITS-1:0] org_c [3];
   logic signed [COORD_BITS-1:0] va_c [3];
   logic signed [COORD_BITS-1:0] vb_c [3];
   logic signed [COORD_BITS-1:0] vc_c [3];

   logic signed [DW-1:0]     e1_ff [3];
   logic signed [DW-1:0]     e2_ff [3];
   logic signed [DW-1:0]     s_ff [3];
   logic signed [CW-1:0]     h_ff [3];
   logic signed [CW-1:0]     q_ff [3];
   logic signed [SW-1:0]     st_ff, det_ff, su_ff, sv_ff;
   logic [OPAC_W-1:0]        op_ff;
   logic                     last_ff;

   logic                     det_neg_ff;
   logic signed [SW:0]       adet_ff, su_n_ff, sv_n_ff;
   logic signed [AW-1:0]     x_ff;
   logic signed [SW+1:0]     uv_sum;
   logic                     hit;
   logic [OPAC_W-1:0]        pass;

   logic [OPAC_W-1:0]        trans_ff, trans_in;
   logic                     hit_ff, hit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OPAC_W-1:0]        rsp_trans_ff;
   logic                     rsp_hit_ff;

   assign accept = req_valid && req_ready;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dir_c[k] = sun_ff[k*COORD_BITS +: COORD_BITS];
         org_c[k] = req_ray_start[k*COORD_BITS +: COORD_BITS];
         va_c[k]  = req_corner_a[k*COORD_BITS +: COORD_BITS];
         vb_c[k]  = req_corner_b[k*COORD_BITS +: COORD_BITS];
         vc_c[k]  = req_corner_c[k*COORD_BITS +: COORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sun_ff <= '0;
      end else if (csr_wr_en) begin
         sun_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= DW'(vb_c[k]) - DW'(va_c[k]);
            e2_ff[k] <= DW'(vc_c[k]) - DW'(va_c[k]);
            s_ff[k]  <= DW'(org_c[k]) - DW'(va_c[k]);
         end
         op_ff   <= (req_opacity > ONE_Q16) ? ONE_Q16 : req_opacity;
         last_ff <= req_last_of_ray;
      end
      if (wr_en) begin
         case (wr_dst)
            W_H:     h_ff[wr_comp] <= CW'(wr_value);
            W_Q:     q_ff[wr_comp] <= CW'(wr_value);
            W_ST:    st_ff <= SW'(wr_value);
            W_DET:   det_ff <= SW'(wr_value);
            W_SU:    su_ff <= SW'(wr_value);
            W_SV:    sv_ff <= SW'(wr_value);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ctrl.a_src)
         A_DIR:   a_op = MW'(dir_c[ctrl.a_comp]);
         A_E1:    a_op = MW'(e1_ff[ctrl.a_comp]);
         A_E2:    a_op = MW'(e2_ff[ctrl.a_comp]);
         A_S:     a_op = MW'(s_ff[ctrl.a_comp]);
         default: begin
            case (ctrl.a_comp)
               2'd0:    a_op = MW'($signed({1'b0, st_ff[SPLIT-1:0]}));
               2'd1:    a_op = MW'($signed({1'b0, st_ff[2*SPLIT-1:SPLIT]}));
               default: a_op = MW'($signed(st_ff[SW-1:2*SPLIT]));
            endcase
         end
      endcase
      case (ctrl.b_src)
         B_E1:    b_op = MW'(e1_ff[ctrl.b_comp]);
         B_E2:    b_op = MW'(e2_ff[ctrl.b_comp]);
         B_H_LO:  b_op = MW'($signed({1'b0, h_ff[ctrl.b_comp][SPLIT-1:0]}));
         B_H_HI:  b_op = MW'($signed(h_ff[ctrl.b_comp][CW-1:SPLIT]));
         B_Q_LO:  b_op = MW'($signed({1'b0, q_ff[ctrl.b_comp][SPLIT-1:0]}));
         B_Q_HI:  b_op = MW'($signed(q_ff[ctrl.b_comp][CW-1:SPLIT]));
         default: b_op = MW'(EPS_INV);
      endcase
   end

   rot_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .hold       (hold),
      .ready      (req_ready),
      .ctrl_valid (ctrl_valid),
      .ctrl       (ctrl),
      .phase      (phase)
   );

   rot_mul_acc u_mul_acc (
      .clock      (clock),
      .reset      (reset),
      .ctrl_valid (ctrl_valid),
      .ctrl       (ctrl),
      .a_op       (a_op),
      .b_op       (b_op),
      .acc        (acc),
      .wr_en      (wr_en),
      .wr_dst     (wr_dst),
      .wr_comp    (wr_comp),
      .wr_value   (wr_value)
   );

   // orient by the determinant sign, then t test as e2.q * 1e6 - det
   always_ff @(posedge clock) begin
      if (phase.cmp1) begin
         det_neg_ff <= det_ff[SW-1];
         adet_ff    <= det_ff[SW-1] ? -(SW+1)'(det_ff) : (SW+1)'(det_ff);
         su_n_ff    <= det_ff[SW-1] ? -(SW+1)'(su_ff) : (SW+1)'(su_ff);
         sv_n_ff    <= det_ff[SW-1] ? -(SW+1)'(sv_ff) : (SW+1)'(sv_ff);
         x_ff       <= acc - AW'(det_ff);
      end
   end

   always_comb begin
      uv_sum = (SW+2)'(su_n_ff) + (SW+2)'(sv_n_ff);
      hit = (adet_ff >= (SW+1)'(EPS_MIN))
         && !su_n_ff[SW] && (su_n_ff <= adet_ff)
         && !sv_n_ff[SW] && (uv_sum <= (SW+2)'(adet_ff))
         && (det_neg_ff ? x_ff[AW-1] : (!x_ff[AW-1] && (x_ff != '0)));
      pass = ONE_Q16 - op_ff;
   end

   assign hold    = last_ff && rsp_valid_ff && !rsp_ready;
   assign advance = phase.cmp2 && !hold;

   always_comb begin
      trans_in     = trans_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && req_first_of_ray) begin
         trans_in = ONE_Q16;
         hit_in   = 1'b0;
      end
      if (advance && hit) begin
         hit_in = 1'b1;
         if (trans_ff > pass) begin
            trans_in = pass;
         end
      end
      if (advance && last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_ff     <= ONE_Q16;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         trans_ff     <= trans_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && last_ff) begin
         rsp_trans_ff <= trans_in;
         rsp_hit_ff   <= hit_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_transmission = rsp_trans_ff;
   assign rsp_any_hit      = rsp_hit_ff;

endmodule

/* src/rot_chk.sv */
`timescale 1ns / 1ps

module rot_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rot_pkg::OPAC_W-1:0]  rsp_transmission,
   input logic                        rsp_any_hit
);
   import rot_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_transmission) && $stable(rsp_any_hit))
      else $error("result item changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while still busy");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_transmission <= ONE_Q16)
      else $error("transmission above one");

   a_no_hit_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_any_hit |-> rsp_transmission == ONE_Q16)
      else $error("transmission lowered without a hit");

endmodule

bind ray_occlusion_transmission_unit rot_chk u_rot_chk (.*);

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import rot_pkg::*;

   typedef logic signed [127:0] acc_type;

   typedef struct {
      logic [FIELD_W-1:0] ray_start;
      logic [FIELD_W-1:0] corner_a;
      logic [FIELD_W-1:0] corner_b;
      logic [FIELD_W-1:0] corner_c;
      logic [OPAC_W-1:0]  opacity;
      logic               first_of_ray;
      logic               last_of_ray;
   } shadow_item_type;

   typedef struct {
      logic [OPAC_W-1:0] transmission;
      logic              any_hit;
   } shadow_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [FIELD_W-1:0]   req_ray_start;
   logic [FIELD_W-1:0]   req_corner_a;
   logic [FIELD_W-1:0]   req_corner_b;
   logic [FIELD_W-1:0]   req_corner_c;
   logic [OPAC_W-1:0]    req_opacity;
   logic                 req_first_of_ray;
   logic                 req_last_of_ray;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [OPAC_W-1:0]    rsp_transmission;
   logic                 rsp_any_hit;
   logic                 csr_wr_en;
   logic [FIELD_W-1:0]   csr_wr_data;

   shadow_result_type    pending_results[$];
   logic [FIELD_W-1:0]   sun_dir;
   logic [OPAC_W-1:0]    light_level;
   logic                 shadow_seen;
   int                   error_count;
   int                   burst_left;
   int                   stall_hold;
   int                   idle_cycles;
   int                   ready_phase;
   int                   ready_mode;

   ray_occlusion_transmission_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ray_start    (req_ray_start),
      .req_corner_a     (req_corner_a),
      .req_corner_b     (req_corner_b),
      .req_corner_c     (req_corner_c),
      .req_opacity      (req_opacity),
      .req_first_of_ray (req_first_of_ray),
      .req_last_of_ray  (req_last_of_ray),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_transmission (rsp_transmission),
      .rsp_any_hit      (rsp_any_hit),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [FIELD_W-1:0] pack3(longint x, longint y, longint z);
      logic [COORD_BITS-1:0] px, py, pz;
      px = x[COORD_BITS-1:0];
      py = y[COORD_BITS-1:0];
      pz = z[COORD_BITS-1:0];
      return {pz, py, px};
   endfunction

   function automatic longint coord_of(logic [FIELD_W-1:0] v, int k);
      logic signed [COORD_BITS-1:0] c;
      c = v[k*COORD_BITS +: COORD_BITS];
      return longint'(c);
   endfunction

   function automatic acc_type dot3(longint x[3], longint y[3]);
      return acc_type'(x[0]) * acc_type'(y[0]) + acc_type'(x[1]) * acc_type'(y[1])
           + acc_type'(x[2]) * acc_type'(y[2]);
   endfunction

   function automatic bit ray_blocked(logic [FIELD_W-1:0] o, logic [FIELD_W-1:0] d,
                                      logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                      logic [FIELD_W-1:0] c);
      longint dv[3], e1[3], e2[3], s[3], h[3], q[3];
      acc_type det, su, sv, st;
      for (int k = 0; k < 3; k++) begin
         dv[k] = coord_of(d, k);
         e1[k] = coord_of(b, k) - coord_of(a, k);
         e2[k] = coord_of(c, k) - coord_of(a, k);
         s[k]  = coord_of(o, k) - coord_of(a, k);
      end
      h[0] = dv[1] * e2[2] - dv[2] * e2[1];
      h[1] = dv[2] * e2[0] - dv[0] * e2[2];
      h[2] = dv[0] * e2[1] - dv[1] * e2[0];
      q[0] = s[1] * e1[2] - s[2] * e1[1];
      q[1] = s[2] * e1[0] - s[0] * e1[2];
      q[2] = s[0] * e1[1] - s[1] * e1[0];
      det = dot3(e1, h);
      su  = dot3(s, h);
      sv  = dot3(dv, q);
      st  = dot3(e2, q);
      if (det < 0) begin
         det = -det;
         su  = -su;
         sv  = -sv;
         st  = -st;
      end
      if (det * acc_type'(1000000) < (acc_type'(1) <<< (3 * FRAC_BITS))) return 1'b0;
      if (su < 0 || su > det) return 1'b0;
      if (sv < 0 || su + sv > det) return 1'b0;
      return st * acc_type'(1000000) > det;
   endfunction

   task automatic predict_shadow(shadow_item_type it);
      logic [OPAC_W-1:0] op, pass;
      shadow_result_type r;
      op = (it.opacity > ONE_Q16) ? ONE_Q16 : it.opacity;
      if (it.first_of_ray) begin
         light_level = ONE_Q16;
         shadow_seen = 1'b0;
      end
      if (ray_blocked(it.ray_start, sun_dir, it.corner_a, it.corner_b, it.corner_c)) begin
         pass = ONE_Q16 - op;
         shadow_seen = 1'b1;
         if (light_level > pass) light_level = pass;
      end
      if (it.last_of_ray) begin
         r.transmission = light_level;
         r.any_hit = shadow_seen;
         pending_results.push_back(r);
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic send_item(shadow_item_type it);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_ray_start    <= it.ray_start;
      req_corner_a     <= it.corner_a;
      req_corner_b     <= it.corner_b;
      req_corner_c     <= it.corner_c;
      req_opacity      <= it.opacity;
      req_first_of_ray <= it.first_of_ray;
      req_last_of_ray  <= it.last_of_ray;
      do @(posedge clock); while (!req_ready);
      predict_shadow(it);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_sun(logic [FIELD_W-1:0] v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sun_dir = v;
      @(posedge clock);
   endtask

   function automatic logic [FIELD_W-1:0] rand_field();
      return FIELD_W'({$urandom, $urandom});
   endfunction

   function automatic logic [OPAC_W-1:0] rand_opacity();
      if ($urandom_range(0, 9) == 0) return OPAC_W'($urandom);
      if ($urandom_range(0, 5) == 0) return ($urandom_range(0, 1) != 0) ? ONE_Q16 : '0;
      return OPAC_W'($urandom_range(0, 65536));
   endfunction

   // a triangle placed somewhere along the sun ray, mostly around the crossing point
   function automatic shadow_item_type geo_item(bit first, bit last);
      shadow_item_type it;
      longint o[3], p[3], u[3], v[3];
      longint k, span;
      k = $urandom_range(0, 7) == 0 ? -longint'($urandom_range(1, 40))
                                    : longint'($urandom_range(1, 40));
      span = $urandom_range(0, 3) == 0 ? 300 : 40000;
      for (int i = 0; i < 3; i++) begin
         o[i] = longint'($urandom_range(0, 400000)) - 200000;
         p[i] = o[i] + coord_of(sun_dir, i) * k;
         u[i] = longint'($urandom_range(0, 2 * span)) - span;
         v[i] = longint'($urandom_range(0, 2 * span)) - span;
      end
      it.ray_start = pack3(o[0], o[1], o[2]);
      if ($urandom_range(0, 9) < 7) begin
         it.corner_a = pack3(p[0] + u[0], p[1] + u[1], p[2] + u[2]);
         it.corner_b = pack3(p[0] + v[0], p[1] + v[1], p[2] + v[2]);
         it.corner_c = pack3(p[0] - u[0] - v[0], p[1] - u[1] - v[1], p[2] - u[2] - v[2]);
      end else begin
         it.corner_a = pack3(p[0] + u[0], p[1] + v[1], p[2] + u[2]);
         it.corner_b = pack3(p[0] + v[0], p[1] - u[1], p[2] + v[2]);
         it.corner_c = pack3(p[0] - v[0], p[1] + u[1], p[2] - u[2]);
      end
      it.opacity = rand_opacity();
      it.first_of_ray = first;
      it.last_of_ray = last;
      return it;
   endfunction

   task automatic send_rays(int item_total);
      shadow_item_type it;
      int n, len;
      n = 0;
      while (n < item_total) begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               it.ray_start = rand_field();
               it.corner_a = rand_field();
               it.corner_b = rand_field();
               it.corner_c = rand_field();
               it.opacity = OPAC_W'($urandom);
               it.first_of_ray = 1'($urandom);
               it.last_of_ray = 1'($urandom);
            end else begin
               it = geo_item(i == 0, i == len - 1);
               if ($urandom_range(0, 19) == 0) it.first_of_ray = ~it.first_of_ray;
               if ($urandom_range(0, 19) == 0) it.last_of_ray = ~it.last_of_ray;
            end
            send_item(it);
            n++;
         end
      end
   endtask

   function automatic shadow_item_type make_item(logic [FIELD_W-1:0] o, logic [FIELD_W-1:0] a,
                                                 logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] c,
                                                 logic [OPAC_W-1:0] op, bit first, bit last);
      shadow_item_type it;
      it.ray_start = o;
      it.corner_a = a;
      it.corner_b = b;
      it.corner_c = c;
      it.opacity = op;
      it.first_of_ray = first;
      it.last_of_ray = last;
      return it;
   endfunction

   task automatic test_directed();
      logic [FIELD_W-1:0] o, a, b, c, ones;
      o = pack3(0, 0, 0);
      a = pack3(-4096, -4096, 8192);
      b = pack3(4096, -4096, 8192);
      c = pack3(0, 4096, 8192);
      ones = '1;
      set_sun(pack3(0, 0, 1024));
      send_item(make_item(o, a, b, c, ONE_Q16, 1, 1));
      send_item(make_item(o, a, b, c, 17'd0, 1, 1));
      send_item(make_item(o, a, b, c, 17'h1FFFF, 1, 1));
      send_item(make_item(o, a, b, c, 17'd20000, 1, 0));
      send_item(make_item(o, a, b, c, 17'd50000, 0, 0));
      send_item(make_item(o, a, b, c, 17'd10000, 0, 1));
      // no first flag: state carries on
      send_item(make_item(o, a, b, c, 17'd60000, 0, 1));
      // triangle behind origin
      send_item(make_item(o, pack3(-4096, -4096, -8192), pack3(4096, -4096, -8192),
                          pack3(0, 4096, -8192), ONE_Q16, 1, 1));
      // triangle parallel to the ray
      send_item(make_item(o, pack3(100, -4096, 0), pack3(100, 4096, 0),
                          pack3(100, 0, 8192), ONE_Q16, 1, 1));
      send_item(make_item(ones, ones, ones, ones, 17'h1FFFF, 1, 1));
      send_item(make_item('0, '0, '0, '0, '0, 1, 1));
      send_item(make_item(ones, '0, ones, pack3(-1048576, 1048575, -1048576),
                          ONE_Q16, 1, 1));
      set_sun('0);
      send_item(make_item(o, a, b, c, ONE_Q16, 1, 1));
      send_item(make_item(ones, a, b, c, ONE_Q16, 1, 1));
   endtask

   task automatic test_sun_settings();
      set_sun('1);
      send_rays(60);
      set_sun(pack3(1048575, 1048575, 1048575));
      send_rays(60);
      set_sun(pack3(-1048576, -1048576, -1048576));
      send_rays(60);
      set_sun(63'h7FFF_FFFF_FFFF_FFFF);
      send_rays(40);
      for (int i = 0; i < 6; i++) begin
         set_sun(pack3(longint'($urandom_range(0, 8000)) - 4000,
                       longint'($urandom_range(0, 8000)) - 4000,
                       longint'($urandom_range(0, 8000)) - 4000));
         send_rays(230);
      end
   endtask

   task automatic test_backpressure();
      set_sun(pack3(300, -200, 1024));
      stall_hold = 600;
      send_rays(40);
      send_rays(60);
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_ray_start    <= '0;
      req_corner_a     <= '0;
      req_corner_b     <= '0;
      req_corner_c     <= '0;
      req_opacity      <= '0;
      req_first_of_ray <= 1'b0;
      req_last_of_ray  <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      sun_dir = '0;
      light_level = ONE_Q16;
      shadow_seen = 1'b0;
      error_count = 0;
      burst_left = 0;
      stall_hold = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_sun_settings();
      test_backpressure();
      wait_drained();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // receiver stall pattern, with a long hold when asked
   initial begin
      rsp_ready <= 1'b0;
      ready_phase = 0;
      ready_mode = 0;
      forever begin
         @(posedge clock);
         if (ready_phase == 0) begin
            ready_phase = $urandom_range(50, 300);
            ready_mode = $urandom_range(0, 2);
         end
         ready_phase--;
         if (stall_hold > 0) begin
            stall_hold--;
            rsp_ready <= 1'b0;
         end else if (ready_mode == 0) begin
            rsp_ready <= 1'b1;
         end else if (ready_mode == 1) begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end else begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   always @(posedge clock) begin
      shadow_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_transmission, -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_transmission !== want.transmission)
               report_mismatch("transmission", rsp_transmission, want.transmission);
            if (rsp_any_hit !== want.any_hit)
               report_mismatch("any_hit", rsp_any_hit, want.any_hit);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 4000) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule
